// ----- rtl/core/rlh_pkg.sv -----
package rlh_pkg;

    localparam int BINS  = 256;
    localparam int BIN_W = 8;

    // Operation codes on the input channel
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Channel numbers
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_LUMA  = 2'd3;

    // Luma weights in thousandths; the weighted sum fits in 18 bits (max 255000)
    localparam int          SUM_W   = 18;
    localparam logic [17:0] LUMA_WR = 18'd299;
    localparam logic [17:0] LUMA_WG = 18'd587;
    localparam logic [17:0] LUMA_WB = 18'd114;

    // floor(s / 1000) == (s * ceil(2^30 / 1000)) >> 30 for every s below 6e6
    localparam int          PROD_W     = 39;
    localparam int          LUMA_SHIFT = 30;
    localparam logic [38:0] LUMA_RECIP = 39'd1073742;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [1:0]       op;
        logic [BIN_W-1:0] red;
        logic [BIN_W-1:0] green;
        logic [BIN_W-1:0] blue;
        logic [BIN_W-1:0] luma;
        logic [BIN_W-1:0] bin_index;
    } t_item;

    function automatic logic [BIN_W-1:0] item_bin(input t_item it, input logic [1:0] ch);
        logic [BIN_W-1:0] bin;
        case (ch)
            CH_RED:   bin = it.red;
            CH_GREEN: bin = it.green;
            CH_BLUE:  bin = it.blue;
            CH_LUMA:  bin = it.luma;
            default:  bin = it.luma;
        endcase
        return bin;
    endfunction

endpackage

// ----- rtl/core/rlh_ram.sv -----
module rlh_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/rlh_front.sv -----
module rlh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_operation,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_bin_index,
    output logic          o_push,
    output rlh_pkg::t_item o_item,
    input  logic          i_full
);

    import rlh_pkg::*;

    logic              r_s1_v;
    t_item             r_s1_item;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s2_v;
    t_item             r_s2_item;

    logic              s2_free;
    logic              s1_move;
    logic              accept;
    logic [SUM_W-1:0]  n_sum;
    logic [PROD_W-1:0] prod;
    t_item             n_s2_item;

    assign o_push  = r_s2_v && !i_full;
    assign s2_free = !r_s2_v || o_push;
    assign s1_move = r_s1_v && s2_free;
    assign o_ready = (!r_s1_v || s1_move) && !i_hold;
    assign accept  = i_valid && o_ready;
    assign o_item  = r_s2_item;

    assign n_sum = SUM_W'(i_red) * LUMA_WR + SUM_W'(i_green) * LUMA_WG
                 + SUM_W'(i_blue) * LUMA_WB;
    assign prod  = PROD_W'(r_s1_sum) * LUMA_RECIP;

    always_comb begin
        n_s2_item      = r_s1_item;
        n_s2_item.luma = prod[LUMA_SHIFT+BIN_W-1:LUMA_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            // unused operation code is accepted and dropped here
            if (accept) begin
                r_s1_v <= (i_operation == OP_CLEAR) || (i_operation == OP_ACCUM)
                       || (i_operation == OP_READ);
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (o_push) begin
                r_s2_v <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_item.op        <= i_operation;
            r_s1_item.red       <= i_red;
            r_s1_item.green     <= i_green;
            r_s1_item.blue      <= i_blue;
            r_s1_item.luma      <= '0;
            r_s1_item.bin_index <= i_bin_index;
            r_s1_sum            <= n_sum;
        end
        if (s1_move) begin
            r_s2_item <= n_s2_item;
        end
    end

endmodule

// ----- rtl/core/rlh_queue.sv -----
module rlh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlh_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output rlh_pkg::t_item o_head,
    output logic           o_empty
);

    import rlh_pkg::*;

    t_item           r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/core/rlh_back.sv -----
module rlh_back #(
    parameter int COUNT_WIDTH = 15,
    parameter int CHANNELS    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_channel_select,
    input  rlh_pkg::t_item         i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_init_busy,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COUNT_WIDTH-1:0] o_bin_count,
    output logic [COUNT_WIDTH-1:0] o_max_count
);

    import rlh_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state                 r_state;
    logic [BIN_W-1:0]       r_sweep;
    logic                   r_init;
    logic                   r_is_read;
    logic [BIN_W-1:0]       r_bin [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_max [CHANNELS];
    logic                   r_out_valid;
    logic [COUNT_WIDTH-1:0] r_out_bin;
    logic [COUNT_WIDTH-1:0] r_out_max;

    logic [BIN_W-1:0]       rd_addr [CHANNELS];
    logic [BIN_W-1:0]       wr_addr [CHANNELS];
    logic [COUNT_WIDTH-1:0] wr_data [CHANNELS];
    logic [COUNT_WIDTH-1:0] rd_data [CHANNELS];
    logic [COUNT_WIDTH-1:0] inc     [CHANNELS];
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] sel_bin;
    logic [COUNT_WIDTH-1:0] sel_max;

    // a read may only start when the result register is free by the time data returns
    assign o_pop = (r_state == S_IDLE) && !i_empty
                && ((i_head.op != OP_READ) || !r_out_valid || i_ready);
    assign wr_en = (r_state == S_CLEAR) || ((r_state == S_LOOK) && !r_is_read);

    always_comb begin
        sel_bin = '0;
        sel_max = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            rd_addr[c] = (i_head.op == OP_READ) ? i_head.bin_index : item_bin(i_head, 2'(c));
            inc[c]     = (rd_data[c] == '1) ? rd_data[c]
                       : rd_data[c] + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            wr_addr[c] = (r_state == S_CLEAR) ? r_sweep : r_bin[c];
            wr_data[c] = (r_state == S_CLEAR) ? '0 : inc[c];
            if (i_channel_select == 2'(c)) begin
                sel_bin = rd_data[c];
                sel_max = r_max[c];
            end
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_ram
        rlh_ram #(
            .WIDTH(COUNT_WIDTH),
            .DEPTH(BINS)
        ) u_ram (
            .i_clk    (i_clk),
            .i_wr_en  (wr_en),
            .i_wr_addr(wr_addr[g]),
            .i_wr_data(wr_data[g]),
            .i_rd_addr(rd_addr[g]),
            .o_rd_data(rd_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_max[c] <= '0;
            end
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == '1) begin
                        r_state <= S_IDLE;
                        r_init  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_head.op == OP_CLEAR) begin
                            r_state <= S_CLEAR;
                            r_sweep <= '0;
                            for (int c = 0; c < CHANNELS; c++) begin
                                r_max[c] <= '0;
                            end
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    r_state <= S_IDLE;
                    if (r_is_read) begin
                        r_out_valid <= 1'b1;
                    end else begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (inc[c] > r_max[c]) begin
                                r_max[c] <= inc[c];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (o_pop) begin
            r_is_read <= (i_head.op == OP_READ);
            for (int c = 0; c < CHANNELS; c++) begin
                r_bin[c] <= rd_addr[c];
            end
        end
        if ((r_state == S_LOOK) && r_is_read) begin
            r_out_bin <= sel_bin;
            r_out_max <= sel_max;
        end
    end

    assign o_init_busy = r_init;
    assign o_valid     = r_out_valid;
    assign o_bin_count = r_out_bin;
    assign o_max_count = r_out_max;

endmodule

// ----- rtl/core/rgb_luma_histogram_core.sv -----
// RGB and luma histogram: four 256-bin histograms (red, green, blue and luma, with
// luma = floor((299r + 587g + 114b) / 1000)), each bin a saturating counter, plus a
// running maximum per channel. The front end takes one item per cycle, unless held by a
// full queue or reset sweep, into a two-stage pipe that computes luma, then a 4-entry
// queue; the back end works one item at a time on one single-port-write RAM per channel:
// an accumulate or a read does a RAM read, then a write or the result. A read result
// passes the two pipe stages, the queue, the RAM read and the result register. A clear
// sweeps the RAMs one address per cycle; the same sweep runs after reset, during which
// no item is accepted (configuration writes still are). channel_select at byte address 0
// picks the channel returned by reads; write it only while the block is idle.
module rgb_luma_histogram_core #(
    parameter int COUNT_WIDTH = 15,
    parameter int CHANNELS    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_operation,
    input  logic [7:0]             i_red,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_blue,
    input  logic [7:0]             i_bin_index,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COUNT_WIDTH-1:0] o_bin_count,
    output logic [COUNT_WIDTH-1:0] o_max_count,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    import rlh_pkg::*;

    logic [1:0] r_channel_select;
    logic       push;
    t_item      front_item;
    logic       full;
    logic       pop;
    t_item      head;
    logic       empty;
    logic       init_busy;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {30'd0, r_channel_select};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_select <= CH_RED;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_channel_select <= pwdata[1:0];
        end
    end

    rlh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (init_busy),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_operation(i_operation),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .i_bin_index(i_bin_index),
        .o_push     (push),
        .o_item     (front_item),
        .i_full     (full)
    );

    rlh_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (front_item),
        .o_full (full),
        .i_pop  (pop),
        .o_head (head),
        .o_empty(empty)
    );

    rlh_back #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_channel_select(r_channel_select),
        .i_head          (head),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_init_busy     (init_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bin_count     (o_bin_count),
        .o_max_count     (o_max_count)
    );

endmodule
